// File: rtl/ncs_pkg.sv
package ncs_pkg;

   localparam int MAX_ADDRESS_CYCLES = 4;
   localparam int CNT_W              = 3;
   localparam int STEP_W             = (MAX_ADDRESS_CYCLES > 1) ? $clog2(MAX_ADDRESS_CYCLES) : 1;
   localparam int QUEUE_DEPTH        = 2;
   localparam int POLL_W             = 25;
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [7:0] NO_COMMAND = 8'hFF;
   localparam logic [7:0] STATUS_ERROR_BIT = 8'h01;
   localparam logic [7:0] STATUS_READY_BIT = 8'h40;

   localparam logic [2:0]        ROW_COUNT_RESET    = 3'd3;
   localparam logic [2:0]        COL_COUNT_RESET    = 3'd2;
   localparam logic [31:0]       READ_OPS_RESET     = 32'h90FF3000;
   localparam logic [31:0]       PE_OPS_RESET       = 32'hD0601080;
   localparam logic [23:0]       MISC_OPS_RESET     = 24'hEF70FF;
   localparam logic [23:0]       ECC_WORDS_RESET    = 24'h000890;
   localparam logic [POLL_W-1:0] POLL_LIMIT_RESET   = 25'h1000000;

   typedef enum logic [3:0] {
      MODE_RESET    = 4'd0,
      MODE_READ     = 4'd1,
      MODE_SPARE    = 4'd2,
      MODE_PROGRAM  = 4'd3,
      MODE_DATA     = 4'd4,
      MODE_STROBE   = 4'd5,
      MODE_ERASE    = 4'd6,
      MODE_ID       = 4'd7,
      MODE_FEATURES = 4'd8,
      MODE_POLL     = 4'd9
   } ncs_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT  = 3'd0,
      CSR_COL_COUNT  = 3'd1,
      CSR_READ_OPS   = 3'd2,
      CSR_PE_OPS     = 3'd3,
      CSR_MISC_OPS   = 3'd4,
      CSR_ECC_WORDS  = 3'd5,
      CSR_POLL_LIMIT = 3'd6
   } ncs_csr_type;

   typedef enum logic [2:0] {
      KIND_CMD    = 3'd0,
      KIND_ADDR   = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_STROBE = 3'd3,
      KIND_REPORT = 3'd4
   } ncs_kind_type;

   typedef enum logic [2:0] {
      ST_NONE    = 3'd0,
      ST_READY   = 3'd1,
      ST_BUSY    = 3'd2,
      ST_ERROR   = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_INVALID = 3'd5
   } ncs_status_type;

   // One request as a fixed template: lead cycle, column bytes, row bytes,
   // optional trailing cycle, then a run of zero data writes.
   typedef struct packed {
      ncs_kind_type   lead_kind;
      logic [7:0]     lead_byte;
      ncs_status_type lead_status;
      logic [CNT_W-1:0] col_count;
      logic [31:0]    col_value;
      logic [CNT_W-1:0] row_count;
      logic [31:0]    row_value;
      logic           trail_valid;
      ncs_kind_type   trail_kind;
      logic [7:0]     trail_byte;
      ncs_status_type trail_status;
      logic [1:0]     zero_count;
   } ncs_job_type;

   function automatic logic [7:0] addr_byte(logic [31:0] value, logic [STEP_W-1:0] idx);
      logic [31:0] sh;
      sh = value >> {idx, 3'b000};
      return sh[7:0];
   endfunction

endpackage

// File: rtl/nand_command_sequencer_top.sv
// NAND command sequencer: each request transferred in on push/full becomes
// one to ten NAND bus cycles transferred out on empty/pop, one result per
// clock while results are popped, with rsp_run_end set on the last result
// of the request. The front end classifies a request in the cycle it is
// transferred (opcode lookup, address cycle counts, status poll
// classification and the busy-poll counter) and writes a compact job
// descriptor into a two-entry queue. The back end walks the descriptor one
// bus cycle per clock into an output register while that register is free
// or popped. A request has one bus cycle for reset, strobe or an invalid
// report, two for poll and ID, and up to ten for a page read with four
// column and four row bytes. Requests can be pushed every clock while the
// queue has room, and a waiting result does not stop the next request from
// being taken. A request is written into the queue, and its first result is
// then registered in the output register. Configuration writes take effect
// the next clock and must only be issued while no request is in flight.
module nand_command_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ncs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ncs_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            push,
   output logic                            full,
   input  logic [3:0]                      req_mode,
   input  logic [31:0]                     req_row_address,
   input  logic [31:0]                     req_column_address,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_final_byte,
   input  logic                            req_ecc_enable,
   input  logic [7:0]                      req_status_byte,
   output logic                            empty,
   input  logic                            pop,
   output logic [2:0]                      rsp_cycle_kind,
   output logic [7:0]                      rsp_bus_byte,
   output logic [2:0]                      rsp_result_status,
   output logic                            rsp_run_end
);

   ncs_pkg::ncs_job_type front_job;
   ncs_pkg::ncs_job_type head_job;
   logic                 accept;
   logic                 q_empty;
   logic                 job_done;

   // a request transfer happens whenever push is high and the queue has a free slot
   assign accept = push && !full;

   ncs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .accept             (accept),
      .req_mode           (req_mode),
      .req_row_address    (req_row_address),
      .req_column_address (req_column_address),
      .req_data_byte      (req_data_byte),
      .req_final_byte     (req_final_byte),
      .req_ecc_enable     (req_ecc_enable),
      .req_status_byte    (req_status_byte),
      .job                (front_job)
   );

   // decouples classification from bus cycle generation
   ncs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_job  (front_job),
      .rd_en   (job_done),
      .rd_job  (head_job),
      .q_full  (full),
      .q_empty (q_empty)
   );

   // one bus cycle per clock into the output register while it is free or popped
   ncs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job               (head_job),
      .job_valid         (!q_empty),
      .job_done          (job_done),
      .empty             (empty),
      .pop               (pop),
      .rsp_cycle_kind    (rsp_cycle_kind),
      .rsp_bus_byte      (rsp_bus_byte),
      .rsp_result_status (rsp_result_status),
      .rsp_run_end       (rsp_run_end)
   );

`ifndef SYNTHESIS
   // a job retires only while one is queued
   a_done_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_done |-> !q_empty)
      else $error("job retired from empty queue");

   // retiring a job always leaves its last result in the output register
   a_done_marks_end: assert property (@(posedge clock) disable iff (reset)
      job_done |=> (!empty && rsp_run_end))
      else $error("retired job without run end result");

   // a full queue always has work for the back end
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      full |-> !q_empty)
      else $error("queue full and empty at once");

   // after reset nothing is queued or waiting
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!full && empty && q_empty))
      else $error("state not cleared by reset");
`endif

endmodule

// File: rtl/ncs_front.sv
module ncs_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ncs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ncs_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            accept,
   input  logic [3:0]                      req_mode,
   input  logic [31:0]                     req_row_address,
   input  logic [31:0]                     req_column_address,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_final_byte,
   input  logic                            req_ecc_enable,
   input  logic [7:0]                      req_status_byte,
   output ncs_pkg::ncs_job_type            job
);

   logic [2:0]                   row_addr_len_ff, row_addr_len_in;
   logic [2:0]                   col_addr_len_ff, col_addr_len_in;
   logic [31:0]                  read_ops_ff, read_ops_in;
   logic [31:0]                  pe_ops_ff, pe_ops_in;
   logic [23:0]                  misc_ops_ff, misc_ops_in;
   logic [23:0]                  ecc_words_ff, ecc_words_in;
   logic [ncs_pkg::POLL_W-1:0]   poll_limit_ff, poll_limit_in;
   logic [ncs_pkg::POLL_W-1:0]   busy_count_ff, busy_count_in;
   logic [ncs_pkg::POLL_W-1:0]   busy_inc;
   logic [ncs_pkg::CNT_W-1:0]    col_cnt, row_cnt;
   ncs_pkg::ncs_status_type      poll_status;

   always_comb begin
      row_addr_len_in = row_addr_len_ff;
      col_addr_len_in = col_addr_len_ff;
      read_ops_in     = read_ops_ff;
      pe_ops_in       = pe_ops_ff;
      misc_ops_in     = misc_ops_ff;
      ecc_words_in    = ecc_words_ff;
      poll_limit_in   = poll_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ncs_pkg::CSR_ROW_COUNT:  row_addr_len_in = csr_write_data[2:0];
            ncs_pkg::CSR_COL_COUNT:  col_addr_len_in = csr_write_data[2:0];
            ncs_pkg::CSR_READ_OPS:   read_ops_in     = csr_write_data;
            ncs_pkg::CSR_PE_OPS:     pe_ops_in       = csr_write_data;
            ncs_pkg::CSR_MISC_OPS:   misc_ops_in     = csr_write_data[23:0];
            ncs_pkg::CSR_ECC_WORDS:  ecc_words_in    = csr_write_data[23:0];
            ncs_pkg::CSR_POLL_LIMIT: poll_limit_in   = csr_write_data[ncs_pkg::POLL_W-1:0];
            default: ;
         endcase
      end
   end

   // counts beyond the address width send nothing
   assign col_cnt = (int'(col_addr_len_ff) > ncs_pkg::MAX_ADDRESS_CYCLES) ?
                    '0 : col_addr_len_ff;
   assign row_cnt = (int'(row_addr_len_ff) > ncs_pkg::MAX_ADDRESS_CYCLES) ?
                    '0 : row_addr_len_ff;

   // busy poll bookkeeping
   assign busy_inc = busy_count_ff + 1'b1;

   always_comb begin
      busy_count_in = busy_count_ff;
      poll_status   = ncs_pkg::ST_BUSY;
      if ((req_status_byte & ncs_pkg::STATUS_ERROR_BIT) != '0) begin
         poll_status   = ncs_pkg::ST_ERROR;
         busy_count_in = '0;
      end else if ((req_status_byte & ncs_pkg::STATUS_READY_BIT) != '0) begin
         poll_status   = ncs_pkg::ST_READY;
         busy_count_in = '0;
      end else if (busy_inc >= poll_limit_ff) begin
         poll_status   = ncs_pkg::ST_TIMEOUT;
         busy_count_in = '0;
      end else begin
         busy_count_in = busy_inc;
      end
      if (req_mode != ncs_pkg::MODE_POLL) begin
         busy_count_in = '0;
      end
   end

   always_comb begin
      job              = '0;
      job.lead_kind    = ncs_pkg::KIND_REPORT;
      job.lead_status  = ncs_pkg::ST_INVALID;
      job.trail_kind   = ncs_pkg::KIND_CMD;
      job.trail_status = ncs_pkg::ST_NONE;
      unique case (req_mode)
         ncs_pkg::MODE_RESET: begin
            job.lead_kind   = ncs_pkg::KIND_CMD;
            job.lead_byte   = misc_ops_ff[7:0];
            job.lead_status = ncs_pkg::ST_NONE;
         end
         ncs_pkg::MODE_READ: begin
            job.lead_kind   = ncs_pkg::KIND_CMD;
            job.lead_byte   = read_ops_ff[7:0];
            job.lead_status = ncs_pkg::ST_NONE;
            job.col_count   = col_cnt;
            job.col_value   = req_column_address;
            job.row_count   = row_cnt;
            job.row_value   = req_row_address;
            job.trail_valid = (read_ops_ff[15:8] != ncs_pkg::NO_COMMAND);
            job.trail_byte  = read_ops_ff[15:8];
         end
         ncs_pkg::MODE_SPARE: begin
            if (read_ops_ff[23:16] != ncs_pkg::NO_COMMAND) begin
               job.lead_kind   = ncs_pkg::KIND_CMD;
               job.lead_byte   = read_ops_ff[23:16];
               job.lead_status = ncs_pkg::ST_NONE;
               job.col_count   = col_cnt;
               job.col_value   = req_column_address;
               job.row_count   = row_cnt;
               job.row_value   = req_row_address;
            end
         end
         ncs_pkg::MODE_PROGRAM: begin
            job.lead_kind   = ncs_pkg::KIND_CMD;
            job.lead_byte   = pe_ops_ff[7:0];
            job.lead_status = ncs_pkg::ST_NONE;
            job.col_count   = col_cnt;
            job.row_count   = row_cnt;
            job.row_value   = req_row_address;
         end
         ncs_pkg::MODE_DATA: begin
            job.lead_kind   = ncs_pkg::KIND_DATA;
            job.lead_byte   = req_data_byte;
            job.lead_status = ncs_pkg::ST_NONE;
            job.trail_valid = req_final_byte && (pe_ops_ff[15:8] != ncs_pkg::NO_COMMAND);
            job.trail_byte  = pe_ops_ff[15:8];
         end
         ncs_pkg::MODE_STROBE: begin
            job.lead_kind   = ncs_pkg::KIND_STROBE;
            job.lead_status = ncs_pkg::ST_NONE;
         end
         ncs_pkg::MODE_ERASE: begin
            job.lead_kind   = ncs_pkg::KIND_CMD;
            job.lead_byte   = pe_ops_ff[23:16];
            job.lead_status = ncs_pkg::ST_NONE;
            job.row_count   = row_cnt;
            job.row_value   = req_row_address;
            job.trail_valid = (pe_ops_ff[31:24] != ncs_pkg::NO_COMMAND);
            job.trail_byte  = pe_ops_ff[31:24];
         end
         ncs_pkg::MODE_ID: begin
            job.lead_kind   = ncs_pkg::KIND_CMD;
            job.lead_byte   = read_ops_ff[31:24];
            job.lead_status = ncs_pkg::ST_NONE;
            job.col_count   = ncs_pkg::CNT_W'(1);
         end
         ncs_pkg::MODE_FEATURES: begin
            if (misc_ops_ff[23:16] != ncs_pkg::NO_COMMAND) begin
               job.lead_kind   = ncs_pkg::KIND_CMD;
               job.lead_byte   = misc_ops_ff[23:16];
               job.lead_status = ncs_pkg::ST_NONE;
               job.col_count   = ncs_pkg::CNT_W'(1);
               job.col_value   = {24'd0, ecc_words_ff[7:0]};
               job.trail_valid = 1'b1;
               job.trail_kind  = ncs_pkg::KIND_DATA;
               job.trail_byte  = req_ecc_enable ? ecc_words_ff[15:8] : ecc_words_ff[23:16];
               job.zero_count  = 2'd3;
            end
         end
         ncs_pkg::MODE_POLL: begin
            job.lead_kind    = ncs_pkg::KIND_CMD;
            job.lead_byte    = misc_ops_ff[15:8];
            job.lead_status  = ncs_pkg::ST_NONE;
            job.trail_valid  = 1'b1;
            job.trail_kind   = ncs_pkg::KIND_STROBE;
            job.trail_byte   = req_status_byte;
            job.trail_status = poll_status;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_addr_len_ff <= ncs_pkg::ROW_COUNT_RESET;
         col_addr_len_ff <= ncs_pkg::COL_COUNT_RESET;
         read_ops_ff     <= ncs_pkg::READ_OPS_RESET;
         pe_ops_ff       <= ncs_pkg::PE_OPS_RESET;
         misc_ops_ff     <= ncs_pkg::MISC_OPS_RESET;
         ecc_words_ff    <= ncs_pkg::ECC_WORDS_RESET;
         poll_limit_ff   <= ncs_pkg::POLL_LIMIT_RESET;
         busy_count_ff   <= '0;
      end else begin
         row_addr_len_ff <= row_addr_len_in;
         col_addr_len_ff <= col_addr_len_in;
         read_ops_ff     <= read_ops_in;
         pe_ops_ff       <= pe_ops_in;
         misc_ops_ff     <= misc_ops_in;
         ecc_words_ff    <= ecc_words_in;
         poll_limit_ff   <= poll_limit_in;
         if (accept) begin
            busy_count_ff <= busy_count_in;
         end
      end
   end

endmodule

// File: rtl/ncs_queue.sv
module ncs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  ncs_pkg::ncs_job_type  wr_job,
   input  logic                  rd_en,
   output ncs_pkg::ncs_job_type  rd_job,
   output logic                  q_full,
   output logic                  q_empty
);

   localparam int PTR_W = (ncs_pkg::QUEUE_DEPTH > 1) ? $clog2(ncs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ncs_pkg::QUEUE_DEPTH + 1);

   ncs_pkg::ncs_job_type slot_ff [ncs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign q_full  = (count_ff == CNT_W'(ncs_pkg::QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ncs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ncs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// File: rtl/ncs_back.sv
module ncs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ncs_pkg::ncs_job_type  job,
   input  logic                  job_valid,
   output logic                  job_done,
   output logic                  empty,
   input  logic                  pop,
   output logic [2:0]            rsp_cycle_kind,
   output logic [7:0]            rsp_bus_byte,
   output logic [2:0]            rsp_result_status,
   output logic                  rsp_run_end
);

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_COL   = 5'b00010,
      PH_ROW   = 5'b00100,
      PH_TRAIL = 5'b01000,
      PH_ZERO  = 5'b10000
   } ncs_phase_type;

   ncs_phase_type                 phase_ff, phase_in;
   logic [ncs_pkg::STEP_W-1:0]    idx_ff, idx_in;
   logic                          out_valid_ff, out_valid_in;
   logic [2:0]                    kind_ff, status_ff;
   logic [7:0]                    byte_ff;
   logic                          end_ff;

   logic                          advance;
   logic [ncs_pkg::CNT_W-1:0]     idx_plus;
   logic                          stay;
   logic [4:0]                    avail, later, cand, pick;
   logic                          last;
   ncs_pkg::ncs_kind_type         cur_kind;
   ncs_pkg::ncs_status_type       cur_status;
   logic [7:0]                    cur_byte;

   assign advance  = job_valid && (!out_valid_ff || pop);
   assign idx_plus = ncs_pkg::CNT_W'(idx_ff) + 1'b1;

   always_comb begin
      cur_kind   = ncs_pkg::KIND_ADDR;
      cur_status = ncs_pkg::ST_NONE;
      cur_byte   = '0;
      stay       = 1'b0;
      unique case (phase_ff)
         PH_LEAD: begin
            cur_kind   = job.lead_kind;
            cur_byte   = job.lead_byte;
            cur_status = job.lead_status;
         end
         PH_COL: begin
            cur_byte = ncs_pkg::addr_byte(job.col_value, idx_ff);
            stay     = idx_plus < job.col_count;
         end
         PH_ROW: begin
            cur_byte = ncs_pkg::addr_byte(job.row_value, idx_ff);
            stay     = idx_plus < job.row_count;
         end
         PH_TRAIL: begin
            cur_kind   = job.trail_kind;
            cur_byte   = job.trail_byte;
            cur_status = job.trail_status;
         end
         PH_ZERO: begin
            cur_kind = ncs_pkg::KIND_DATA;
            stay     = idx_plus < ncs_pkg::CNT_W'(job.zero_count);
         end
         default: ;
      endcase
   end

   // next non-empty phase after the current one: lowest set bit above it
   assign avail = {job.zero_count != '0, job.trail_valid, job.row_count != '0,
                   job.col_count != '0, 1'b0};
   assign later = ~(phase_ff | (phase_ff - 5'd1));
   assign cand  = avail & later;
   assign pick  = cand & (~cand + 5'd1);
   assign last  = !stay && (cand == '0);

   assign job_done = advance && last;

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (advance) begin
         if (stay) begin
            idx_in = idx_plus[ncs_pkg::STEP_W-1:0];
         end else begin
            idx_in   = '0;
            phase_in = last ? PH_LEAD : ncs_phase_type'(pick);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff   <= cur_kind;
         byte_ff   <= cur_byte;
         status_ff <= cur_status;
         end_ff    <= last;
      end
   end

   assign empty             = !out_valid_ff;
   assign rsp_cycle_kind    = kind_ff;
   assign rsp_bus_byte      = byte_ff;
   assign rsp_result_status = status_ff;
   assign rsp_run_end       = end_ff;

endmodule

// File: verif/nand_command_sequencer_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the command sequencer,
// predicts the bus cycles of every request and compares them in order.
module nand_command_sequencer_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ncs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ncs_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            push,
   input  logic                            full,
   input  logic [3:0]                      req_mode,
   input  logic [31:0]                     req_row_address,
   input  logic [31:0]                     req_column_address,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_final_byte,
   input  logic                            req_ecc_enable,
   input  logic [7:0]                      req_status_byte,
   input  logic                            empty,
   input  logic                            pop,
   input  logic [2:0]                      rsp_cycle_kind,
   input  logic [7:0]                      rsp_bus_byte,
   input  logic [2:0]                      rsp_result_status,
   input  logic                            rsp_run_end,
   output int                              pending_results,
   output int                              check_failures,
   output int                              results_checked
);
   import ncs_pkg::*;

   typedef struct packed {
      ncs_kind_type   kind;
      logic [7:0]     bus_byte;
      ncs_status_type status;
      logic           run_end;
   } bus_cycle_type;

   bus_cycle_type expected_cycles[$];
   bus_cycle_type oldest_cycle;

   // shadow copy of the register file and the busy-poll counter
   logic [2:0]        row_addr_len;
   logic [2:0]        col_addr_len;
   logic [31:0]       read_ops;
   logic [31:0]       pe_ops;
   logic [23:0]       misc_ops;
   logic [23:0]       ecc_words;
   logic [POLL_W-1:0] poll_limit;
   logic [POLL_W-1:0] busy_polls;

   initial begin
      check_failures  = 0;
      results_checked = 0;
      pending_results = 0;
   end

   function automatic void add_cycle(ncs_kind_type k, logic [7:0] b, ncs_status_type s);
      bus_cycle_type c;
      c.kind     = k;
      c.bus_byte = b;
      c.status   = s;
      c.run_end  = 1'b0;
      expected_cycles.push_back(c);
   endfunction

   // LSB first; an out-of-range count sends nothing
   function automatic void add_address(logic [31:0] value, logic [2:0] count);
      logic [31:0] shifted;
      int i;
      if (count <= MAX_ADDRESS_CYCLES) begin
         for (i = 0; i < count; i++) begin
            shifted = value >> (8 * i);
            add_cycle(KIND_ADDR, shifted[7:0], ST_NONE);
         end
      end
   endfunction

   function automatic void predict_bus_cycles(logic [3:0] mode, logic [31:0] row,
                                              logic [31:0] col, logic [7:0] data,
                                              logic last, logic ecc_on, logic [7:0] sbyte);
      ncs_status_type poll_status;
      bus_cycle_type tail;
      if (mode != MODE_POLL) busy_polls = '0;
      case (mode)
         MODE_RESET: add_cycle(KIND_CMD, misc_ops[7:0], ST_NONE);
         MODE_READ: begin
            add_cycle(KIND_CMD, read_ops[7:0], ST_NONE);
            add_address(col, col_addr_len);
            add_address(row, row_addr_len);
            if (read_ops[15:8] != NO_COMMAND) add_cycle(KIND_CMD, read_ops[15:8], ST_NONE);
         end
         MODE_SPARE: begin
            if (read_ops[23:16] == NO_COMMAND) begin
               add_cycle(KIND_REPORT, 8'h00, ST_INVALID);
            end else begin
               add_cycle(KIND_CMD, read_ops[23:16], ST_NONE);
               add_address(col, col_addr_len);
               add_address(row, row_addr_len);
            end
         end
         MODE_PROGRAM: begin
            add_cycle(KIND_CMD, pe_ops[7:0], ST_NONE);
            add_address(32'h0, col_addr_len);
            add_address(row, row_addr_len);
         end
         MODE_DATA: begin
            add_cycle(KIND_DATA, data, ST_NONE);
            if (last && pe_ops[15:8] != NO_COMMAND) add_cycle(KIND_CMD, pe_ops[15:8], ST_NONE);
         end
         MODE_STROBE: add_cycle(KIND_STROBE, 8'h00, ST_NONE);
         MODE_ERASE: begin
            add_cycle(KIND_CMD, pe_ops[23:16], ST_NONE);
            add_address(row, row_addr_len);
            if (pe_ops[31:24] != NO_COMMAND) add_cycle(KIND_CMD, pe_ops[31:24], ST_NONE);
         end
         MODE_ID: begin
            add_cycle(KIND_CMD, read_ops[31:24], ST_NONE);
            add_cycle(KIND_ADDR, 8'h00, ST_NONE);
         end
         MODE_FEATURES: begin
            if (misc_ops[23:16] == NO_COMMAND) begin
               add_cycle(KIND_REPORT, 8'h00, ST_INVALID);
            end else begin
               add_cycle(KIND_CMD, misc_ops[23:16], ST_NONE);
               add_cycle(KIND_ADDR, ecc_words[7:0], ST_NONE);
               add_cycle(KIND_DATA, ecc_on ? ecc_words[15:8] : ecc_words[23:16], ST_NONE);
               add_cycle(KIND_DATA, 8'h00, ST_NONE);
               add_cycle(KIND_DATA, 8'h00, ST_NONE);
               add_cycle(KIND_DATA, 8'h00, ST_NONE);
            end
         end
         MODE_POLL: begin
            if ((sbyte & STATUS_ERROR_BIT) != 8'h00) begin
               poll_status = ST_ERROR;
               busy_polls  = '0;
            end else if ((sbyte & STATUS_READY_BIT) != 8'h00) begin
               poll_status = ST_READY;
               busy_polls  = '0;
            end else begin
               busy_polls = busy_polls + 1'b1;
               if (busy_polls >= poll_limit) begin
                  poll_status = ST_TIMEOUT;
                  busy_polls  = '0;
               end else begin
                  poll_status = ST_BUSY;
               end
            end
            add_cycle(KIND_CMD, misc_ops[15:8], ST_NONE);
            add_cycle(KIND_STROBE, sbyte, poll_status);
         end
         default: add_cycle(KIND_REPORT, 8'h00, ST_INVALID);
      endcase
      tail = expected_cycles.pop_back();
      tail.run_end = 1'b1;
      expected_cycles.push_back(tail);
   endfunction

   task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
      check_failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_addr_len = ROW_COUNT_RESET;
         col_addr_len = COL_COUNT_RESET;
         read_ops     = READ_OPS_RESET;
         pe_ops       = PE_OPS_RESET;
         misc_ops     = MISC_OPS_RESET;
         ecc_words    = ECC_WORDS_RESET;
         poll_limit   = POLL_LIMIT_RESET;
         busy_polls   = '0;
         expected_cycles.delete();
         pending_results <= 0;
      end else begin
         if (pop && !empty) begin
            results_checked++;
            if (expected_cycles.size() == 0) begin
               check_failures++;
               $display("%0t: unexpected result, kind %0d byte %02h status %0d end %0b",
                        $time, rsp_cycle_kind, rsp_bus_byte, rsp_result_status, rsp_run_end);
            end else begin
               oldest_cycle = expected_cycles.pop_front();
               if (rsp_cycle_kind !== oldest_cycle.kind)
                  note_mismatch("cycle_kind", 8'(oldest_cycle.kind), 8'(rsp_cycle_kind));
               if (rsp_bus_byte !== oldest_cycle.bus_byte)
                  note_mismatch("bus_byte", oldest_cycle.bus_byte, rsp_bus_byte);
               if (rsp_result_status !== oldest_cycle.status)
                  note_mismatch("result_status", 8'(oldest_cycle.status),
                                8'(rsp_result_status));
               if (rsp_run_end !== oldest_cycle.run_end)
                  note_mismatch("run_end", 8'(oldest_cycle.run_end), 8'(rsp_run_end));
            end
         end
         // a request taken at this edge still sees the old register values
         if (push && !full)
            predict_bus_cycles(req_mode, req_row_address, req_column_address, req_data_byte,
                               req_final_byte, req_ecc_enable, req_status_byte);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROW_COUNT:  row_addr_len = csr_write_data[2:0];
               CSR_COL_COUNT:  col_addr_len = csr_write_data[2:0];
               CSR_READ_OPS:   read_ops     = csr_write_data;
               CSR_PE_OPS:     pe_ops       = csr_write_data;
               CSR_MISC_OPS:   misc_ops     = csr_write_data[23:0];
               CSR_ECC_WORDS:  ecc_words    = csr_write_data[23:0];
               CSR_POLL_LIMIT: poll_limit   = csr_write_data[POLL_W-1:0];
               default: ;
            endcase
         end
         pending_results <= expected_cycles.size();
      end
   end

endmodule

// File: verif/tb_nand_command_sequencer_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the NAND command sequencer. The checker beside
// the block does all prediction and comparison; this module only drives
// requests, register writes and the result-side pop, and decides the end.
module tb_nand_command_sequencer_top;
   import ncs_pkg::*;

   localparam int QUIET_LIMIT     = 400;  // cycles without any transfer
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 46;

   typedef struct packed {
      logic [3:0]  mode;
      logic [31:0] row_addr;
      logic [31:0] col_addr;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        ecc_on;
      logic [7:0]  status_byte;
   } nand_req_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;
   logic                  push             = 1'b0;
   logic                  full;
   logic [3:0]            req_mode           = '0;
   logic [31:0]           req_row_address    = '0;
   logic [31:0]           req_column_address = '0;
   logic [7:0]            req_data_byte      = '0;
   logic                  req_final_byte     = 1'b0;
   logic                  req_ecc_enable     = 1'b0;
   logic [7:0]            req_status_byte    = '0;
   logic                  empty;
   logic                  pop              = 1'b0;
   logic [2:0]            rsp_cycle_kind;
   logic [7:0]            rsp_bus_byte;
   logic [2:0]            rsp_result_status;
   logic                  rsp_run_end;

   int   pending_results;
   int   check_failures;
   int   results_checked;
   int   items_sent   = 0;
   int   quiet_cycles = 0;
   int   pop_wait     = 0;
   int   pop_next;
   logic push_idle    = 1'b0;  // sender inserts random gaps this phase
   logic pop_idle     = 1'b0;  // receiver inserts random stalls this phase

   always #5 clock = ~clock;

   nand_command_sequencer_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .push               (push),
      .full               (full),
      .req_mode           (req_mode),
      .req_row_address    (req_row_address),
      .req_column_address (req_column_address),
      .req_data_byte      (req_data_byte),
      .req_final_byte     (req_final_byte),
      .req_ecc_enable     (req_ecc_enable),
      .req_status_byte    (req_status_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_cycle_kind     (rsp_cycle_kind),
      .rsp_bus_byte       (rsp_bus_byte),
      .rsp_result_status  (rsp_result_status),
      .rsp_run_end        (rsp_run_end)
   );

   nand_command_sequencer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .push               (push),
      .full               (full),
      .req_mode           (req_mode),
      .req_row_address    (req_row_address),
      .req_column_address (req_column_address),
      .req_data_byte      (req_data_byte),
      .req_final_byte     (req_final_byte),
      .req_ecc_enable     (req_ecc_enable),
      .req_status_byte    (req_status_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_cycle_kind     (rsp_cycle_kind),
      .rsp_bus_byte       (rsp_bus_byte),
      .rsp_result_status  (rsp_result_status),
      .rsp_run_end        (rsp_run_end),
      .pending_results    (pending_results),
      .check_failures     (check_failures),
      .results_checked    (results_checked)
   );

   // Result side: after each transfer draw a random stall (none when
   // stalls are off this phase). pop is computed once per edge so it is
   // never assigned twice in one time step.
   always @(posedge clock) begin
      if (reset) begin
         pop      <= 1'b0;
         pop_wait <= 0;
      end else begin
         if (pop && !empty) pop_next = pop_idle ? int'($urandom_range(0, 9)) : 0;
         else if (!pop)     pop_next = pop_wait;
         else               pop_next = 0;
         if (pop_next == 0) begin
            pop      <= 1'b1;
            pop_wait <= 0;
         end else begin
            pop      <= 1'b0;
            pop_wait <= pop_next - 1;
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles, %0d results still expected",
               $time, QUIET_LIMIT, pending_results);
      $display("FAIL nand_command_sequencer_top");
      $finish;
   end

   function automatic nand_req_type make_req(logic [3:0] m, logic [31:0] row,
                                             logic [31:0] col, logic [7:0] data,
                                             logic last, logic ecc, logic [7:0] status);
      nand_req_type r;
      r.mode        = m;
      r.row_addr    = row;
      r.col_addr    = col;
      r.data_byte   = data;
      r.last_byte   = last;
      r.ecc_on      = ecc;
      r.status_byte = status;
      return r;
   endfunction

   // every field random; unused fields still toggle on the pins
   function automatic nand_req_type random_req(logic [3:0] m);
      return make_req(m, $urandom, $urandom, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
   endfunction

   // status byte classes: error has bit 0, ready has bit 6 without bit 0
   function automatic logic [7:0] busy_status();
      logic [7:0] s;
      s = 8'($urandom_range(0, 255));
      s = s & ~(STATUS_ERROR_BIT | STATUS_READY_BIT);
      return s;
   endfunction

   function automatic logic [7:0] done_status();
      logic [7:0] s;
      s = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) s = s | STATUS_ERROR_BIT;
      else s = (s & ~STATUS_ERROR_BIT) | STATUS_READY_BIT;
      return s;
   endfunction

   // opcode word with each byte forced to the no-command value now and then
   function automatic logic [31:0] opcode_word();
      logic [31:0] w;
      int b;
      w = $urandom;
      for (b = 0; b < 4; b++)
         if ($urandom_range(0, 3) == 0) w[8*b +: 8] = NO_COMMAND;
      return w;
   endfunction

   // Called at a rising edge; returns at the edge of the transfer with push
   // still high so back-to-back requests go out without a gap.
   task automatic send_req(input nand_req_type r);
      int gap;
      gap = push_idle ? int'($urandom_range(0, 9)) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode           <= r.mode;
      req_row_address    <= r.row_addr;
      req_column_address <= r.col_addr;
      req_data_byte      <= r.data_byte;
      req_final_byte     <= r.last_byte;
      req_ecc_enable     <= r.ecc_on;
      req_status_byte    <= r.status_byte;
      push               <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_poll(input logic [7:0] status);
      nand_req_type r;
      r = random_req(MODE_POLL);
      r.status_byte = status;
      send_req(r);
   endtask

   task automatic write_csr(input ncs_csr_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // rewrites the whole register file; only called with nothing in flight
   task automatic apply_settings(input logic [2:0] rows, input logic [2:0] cols,
                                 input logic [31:0] read_ops, input logic [31:0] pe_ops,
                                 input logic [23:0] misc_ops, input logic [23:0] ecc_words,
                                 input logic [POLL_W-1:0] limit);
      write_csr(CSR_ROW_COUNT, {29'd0, rows});
      write_csr(CSR_COL_COUNT, {29'd0, cols});
      write_csr(CSR_READ_OPS, read_ops);
      write_csr(CSR_PE_OPS, pe_ops);
      write_csr(CSR_MISC_OPS, {8'd0, misc_ops});
      write_csr(CSR_ECC_WORDS, {8'd0, ecc_words});
      write_csr(CSR_POLL_LIMIT, {{(CSR_DATA_W-POLL_W){1'b0}}, limit});
      csr_write_enable <= 1'b0;
   endtask

   // Stop pushing, wait out every expected result, then allow pipeline slack.
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed flows (read + strobes, program + data run, erase or
   // program followed by a busy-poll loop), the rest single random requests
   // including the undefined modes.
   task automatic run_random_items(input int count);
      nand_req_type r;
      int first;
      int n;
      int i;
      int pick;
      first = items_sent;
      while (items_sent - first < count) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: begin
               send_req(random_req(MODE_READ));
               n = $urandom_range(1, 3);
               repeat (n) send_req(random_req(MODE_STROBE));
            end
            2, 3: begin
               send_req(random_req(MODE_PROGRAM));
               n = $urandom_range(1, 4);
               for (i = 1; i <= n; i++) begin
                  r = random_req(MODE_DATA);
                  r.last_byte = (i == n);
                  send_req(r);
               end
            end
            4, 5: begin
               send_req(random_req(pick == 4 ? MODE_ERASE : MODE_PROGRAM));
               n = $urandom_range(0, 6);
               repeat (n) send_poll(busy_status());
               send_poll(done_status());
            end
            6: send_req(random_req(4'($urandom_range(0, 9))));
            default: send_req(random_req(4'($urandom_range(0, 15))));
         endcase
      end
   endtask

   initial begin
      int p;
      logic [2:0]        rows;
      logic [2:0]        cols;
      logic [31:0]       read_ops;
      logic [31:0]       pe_ops;
      logic [23:0]       misc_ops;
      logic [POLL_W-1:0] limit;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset register values: every mode with extreme fields and
      // the error, ready and busy poll classes, plus one undefined mode.
      push_idle <= 1'b1;
      pop_idle  <= 1'b1;
      send_req(make_req(MODE_RESET, 32'h0, 32'h0, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
      send_req(make_req(MODE_SPARE, 32'h12345678, 32'h89ABCDEF, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_PROGRAM, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_DATA, 32'h0, 32'h0, 8'hFF, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_DATA, 32'h0, 32'h0, 8'h00, 1'b1, 1'b0, 8'h00));
      send_req(make_req(MODE_STROBE, 32'hFFFFFFFF, 32'h0, 8'h00, 1'b0, 1'b0, 8'hFF));
      send_req(make_req(MODE_ERASE, 32'hA5A5A5A5, 32'h0, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_ID, 32'h0, 32'h0, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_FEATURES, 32'h0, 32'h0, 8'h00, 1'b0, 1'b1, 8'h00));
      send_req(make_req(MODE_FEATURES, 32'h0, 32'h0, 8'h00, 1'b0, 1'b0, 8'h00));
      send_poll(8'h01);   // error
      send_poll(8'h41);   // error wins over ready
      send_poll(8'h40);   // ready
      send_poll(8'h00);   // busy
      send_poll(8'hBE);   // busy, every other bit set
      send_req(make_req(4'd10, 32'h0, 32'h0, 8'h00, 1'b0, 1'b0, 8'h00));
      drain();

      // Directed, stripped opcodes: missing spare and set-features commands,
      // all optional second commands absent, a column count out of range,
      // four row bytes, and a zero poll limit so every busy poll times out.
      apply_settings(3'd4, 3'd7, 32'h00FFFF00, 32'hFF60FF80, 24'hFF70FF, 24'h5AA53C, '0);
      send_req(make_req(MODE_READ, 32'h89ABCDEF, 32'h01234567, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_SPARE, 32'h0, 32'h0, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_PROGRAM, 32'h76543210, 32'hFFFFFFFF, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_DATA, 32'h0, 32'h0, 8'h5A, 1'b1, 1'b0, 8'h00));
      send_req(make_req(MODE_ERASE, 32'hFEDCBA98, 32'h0, 8'h00, 1'b0, 1'b0, 8'h00));
      send_req(make_req(MODE_FEATURES, 32'h0, 32'h0, 8'h00, 1'b0, 1'b1, 8'h00));
      send_req(make_req(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
      send_poll(8'h00);
      drain();

      // Random phases. Cycle counts and opcode words hit their extremes in
      // fixed phases; poll limits stay small but for phase 1, so busy loops can reach timeout.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         rows     = (p == 0) ? 3'd0 : (p == 1) ? 3'd4 : 3'($urandom_range(0, 7));
         cols     = (p == 0) ? 3'd4 : (p == 1) ? 3'd0 : 3'($urandom_range(0, 7));
         read_ops = (p == 2) ? 32'h0 : (p == 3) ? 32'hFFFFFFFF : opcode_word();
         pe_ops   = (p == 2) ? 32'h0 : (p == 3) ? 32'hFFFFFFFF : opcode_word();
         misc_ops = (p == 2) ? 24'h0 : (p == 3) ? 24'hFFFFFF : 24'(opcode_word());
         case (p)
            0:       limit = 25'd1;
            1:       limit = 25'h1000000;
            2:       limit = 25'd3;
            4:       limit = 25'd2;
            default: limit = 25'($urandom_range(1, 6));
         endcase
         apply_settings(rows, cols, read_ops, pe_ops, misc_ops,
                        (p == 2) ? 24'h0 : (p == 3) ? 24'hFFFFFF : 24'($urandom), limit);
         // one phase runs flat out on both sides
         push_idle <= (p != 1) && ($urandom_range(0, 3) != 0);
         pop_idle  <= (p != 1) && ($urandom_range(0, 3) != 0);
         run_random_items(ITEMS_PER_PHASE);
         drain();
      end

      repeat (8) @(posedge clock);
      $display("Ran %0d requests through %0d register settings, %0d bus cycles checked.",
               items_sent, RANDOM_PHASES + 2, results_checked);
      $display("Included missing opcodes, out-of-range cycle counts, poll limits 0 to max.");
      if (check_failures == 0 && pending_results == 0) begin
         $display("PASS nand_command_sequencer_top");
      end else begin
         $display("FAIL nand_command_sequencer_top");
      end
      $finish;
   end

endmodule
